FILE: sv/uartrb_pkg.sv
package uartrb_pkg;

	// Item kinds carried in the low bits of the input tdata.
	typedef enum logic [1:0] {
		ACT_RX_BYTE  = 2'd0,
		ACT_HOST_WR  = 2'd1,
		ACT_HOST_RD  = 2'd2,
		ACT_TX_DONE  = 2'd3
	} action_t;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 136;

	// Result item; the last member sits in the lowest bits.
	typedef struct packed {
		logic [BYTE_W-1:0]  last_received;
		logic [COUNT_W-1:0] sent_total;
		logic [COUNT_W-1:0] received_total;
		logic [COUNT_W-1:0] dropped_total;
		logic [BYTE_W-1:0]  segment_length;
		logic [BYTE_W-1:0]  segment_offset;
		logic               segment_start;
		logic [BYTE_W-1:0]  read_data;
		logic               accepted;
	} result_t;

	localparam int unsigned RESULT_W = $bits(result_t);

endpackage

FILE: sv/uartrb_ram.sv
module uartrb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/uartrb_core.sv
module uartrb_core #(
	parameter int unsigned RING_DEPTH = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              process,
	input  logic                              out_ready,
	input  uartrb_pkg::action_t               action,
	input  logic [uartrb_pkg::BYTE_W-1:0]     data_byte,
	input  logic [uartrb_pkg::BYTE_W-1:0]     ram_rdata,
	output logic                              ram_we,
	output logic [$clog2(RING_DEPTH)-1:0]     ram_waddr,
	output logic                              ram_re,
	output logic [$clog2(RING_DEPTH)-1:0]     ram_raddr,
	output logic                              out_valid,
	output uartrb_pkg::result_t               result
);

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam logic [AW:0] DEPTH_W = (AW+1)'(RING_DEPTH);

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
		logic [AW:0] inc;
		inc = {1'b0, idx} + (AW+1)'(1);
		return (inc == DEPTH_W) ? '0 : inc[AW-1:0];
	endfunction

	logic [AW-1:0] rx_head_q, rx_tail_q, tx_head_q, tx_tail_q, inflight_q;
	logic [uartrb_pkg::COUNT_W-1:0] drop_q, recv_q, sent_q;
	logic [uartrb_pkg::BYTE_W-1:0]  last_q;

	logic [AW-1:0] rx_head_n, rx_tail_n, tx_head_n, tx_tail_n, inflight_n;
	logic [uartrb_pkg::COUNT_W-1:0] drop_n, recv_n, sent_n;
	logic [uartrb_pkg::BYTE_W-1:0]  last_n;
	logic          acc, rd_ok, seg, we, re;
	logic [AW-1:0] seg_len;
	logic [AW:0]   tail_sum;

	logic                          valid_s2, acc_s2, rd_ok_s2, seg_s2;
	logic [uartrb_pkg::BYTE_W-1:0] off_s2, len_s2;

	always_comb begin
		rx_head_n  = rx_head_q;
		rx_tail_n  = rx_tail_q;
		tx_head_n  = tx_head_q;
		tx_tail_n  = tx_tail_q;
		inflight_n = inflight_q;
		drop_n     = drop_q;
		recv_n     = recv_q;
		sent_n     = sent_q;
		last_n     = last_q;
		acc        = 1'b0;
		rd_ok      = 1'b0;
		seg        = 1'b0;
		we         = 1'b0;
		re         = 1'b0;
		seg_len    = '0;
		tail_sum   = {1'b0, tx_tail_q} + {1'b0, inflight_q};
		case (action)
			uartrb_pkg::ACT_RX_BYTE: begin
				last_n = data_byte;
				recv_n = recv_q + 1'b1;
				if (next_idx(rx_head_q) == rx_tail_q) begin
					drop_n = drop_q + 1'b1;
				end else begin
					we        = 1'b1;
					rx_head_n = next_idx(rx_head_q);
					acc       = 1'b1;
				end
			end
			uartrb_pkg::ACT_HOST_WR: begin
				if (next_idx(tx_head_q) == tx_tail_q) begin
					drop_n = drop_q + 1'b1;
				end else begin
					tx_head_n = next_idx(tx_head_q);
					acc       = 1'b1;
				end
			end
			uartrb_pkg::ACT_HOST_RD: begin
				if (rx_tail_q != rx_head_q) begin
					re        = 1'b1;
					rd_ok     = 1'b1;
					rx_tail_n = next_idx(rx_tail_q);
					acc       = 1'b1;
				end
			end
			uartrb_pkg::ACT_TX_DONE: begin
				// A segment never runs past the end of the buffer, so the sum
				// reaches the depth at most.
				tx_tail_n  = (tail_sum == DEPTH_W) ? '0 : tail_sum[AW-1:0];
				sent_n     = sent_q + uartrb_pkg::COUNT_W'(inflight_q);
				inflight_n = '0;
			end
			default: begin
			end
		endcase

		if (inflight_n == '0 && tx_tail_n != tx_head_n) begin
			if (tx_head_n > tx_tail_n) begin
				seg_len = tx_head_n - tx_tail_n;
			end else begin
				seg_len = AW'(DEPTH_W - {1'b0, tx_tail_n});
			end
			inflight_n = seg_len;
			seg        = 1'b1;
		end
	end

	assign ram_we    = process && we;
	assign ram_waddr = rx_head_q;
	assign ram_re    = process && re;
	assign ram_raddr = rx_tail_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q  <= '0;
			rx_tail_q  <= '0;
			tx_head_q  <= '0;
			tx_tail_q  <= '0;
			inflight_q <= '0;
			drop_q     <= '0;
			recv_q     <= '0;
			sent_q     <= '0;
			last_q     <= '0;
			valid_s2   <= 1'b0;
		end else begin
			if (process) begin
				rx_head_q  <= rx_head_n;
				rx_tail_q  <= rx_tail_n;
				tx_head_q  <= tx_head_n;
				tx_tail_q  <= tx_tail_n;
				inflight_q <= inflight_n;
				drop_q     <= drop_n;
				recv_q     <= recv_n;
				sent_q     <= sent_n;
				last_q     <= last_n;
				valid_s2   <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			acc_s2   <= acc;
			rd_ok_s2 <= rd_ok;
			seg_s2   <= seg;
			off_s2   <= seg ? uartrb_pkg::BYTE_W'(tx_tail_n) : '0;
			len_s2   <= uartrb_pkg::BYTE_W'(seg_len);
		end
	end

	// The counters are shown straight from the state, which only moves when
	// the result register takes a new item.
	assign out_valid              = valid_s2;
	assign result.accepted        = acc_s2;
	assign result.read_data       = rd_ok_s2 ? ram_rdata : '0;
	assign result.segment_start   = seg_s2;
	assign result.segment_offset  = off_s2;
	assign result.segment_length  = len_s2;
	assign result.dropped_total   = drop_q;
	assign result.received_total  = recv_q;
	assign result.sent_total      = sent_q;
	assign result.last_received   = last_q;

endmodule

FILE: sv/uart_ring_buffers_with_dma_segments_top.sv
// UART receive and transmit rings with contiguous DMA transmit segments.
// Each input transfer is one event: a line byte, a host write, a host read or
// a transmit completion. Every event yields exactly one result transfer with
// the read byte, any newly issued segment (offset and length) and the running
// drop, receive and sent counters. The block takes one event per cycle while
// the sink takes results. An event waits in the input register until the
// result register can take it; that load comes together with the registered
// read of the receive ring memory. While the sink holds back a result, the
// input register stays full and the input stalls. The receive ring is a
// RING_DEPTH by 8 memory; its contents are undefined until written and no
// clearing pass is needed.
module uart_ring_buffers_with_dma_segments_top #(
	parameter int unsigned RING_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [1:0] action, [9:2] data_byte, [15:10] zero
	input  logic [15:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [0] accepted, [8:1] read_data, [9] segment_start, [17:10] segment_offset,
	// [25:18] segment_length, [57:26] dropped_total, [89:58] received_total,
	// [121:90] sent_total, [129:122] last_received, [135:130] zero
	output logic [135:0] m_axis_tdata
);

	localparam int unsigned AW = $clog2(RING_DEPTH);

	logic                          valid_s1;
	uartrb_pkg::action_t           action_s1;
	logic [uartrb_pkg::BYTE_W-1:0] byte_s1;
	logic                          advance, process;

	logic                          ram_we, ram_re;
	logic [AW-1:0]                 ram_waddr, ram_raddr;
	logic [uartrb_pkg::BYTE_W-1:0] ram_rdata;
	uartrb_pkg::result_t           result;

	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign process       = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_s1 <= uartrb_pkg::action_t'(s_axis_tdata[1:0]);
			byte_s1   <= s_axis_tdata[9:2];
		end
	end

	uartrb_ram #(
		.WIDTH (uartrb_pkg::BYTE_W),
		.DEPTH (RING_DEPTH)
	) u_rx_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (byte_s1),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	uartrb_core #(
		.RING_DEPTH (RING_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.process   (process),
		.out_ready (m_axis_tready),
		.action    (action_s1),
		.data_byte (byte_s1),
		.ram_rdata (ram_rdata),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.out_valid (m_axis_tvalid),
		.result    (result)
	);

	assign m_axis_tdata = {(uartrb_pkg::OUT_TDATA_W - uartrb_pkg::RESULT_W)'(0), result};

	// Input stalls only while a finished result is held back by the sink.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a blocked result");

	a_seg_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && result.segment_start) |-> (result.segment_length != '0 ||
		RING_DEPTH > 256))
		else $error("issued transmit segment has zero length");

	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !result.accepted) |-> (result.read_data == '0))
		else $error("read data present on a refused item");

	// A write into the receive ring and a pop from it never share a cycle.
	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("receive ring written and read by one item");

endmodule
